@@ hdl/ksdq_pkg.sv @@
// ----------------------------------------------------------------------------
// ksdq_pkg
// Shared sizes, codes and types of the keyed serializing dispatch queue.
// ----------------------------------------------------------------------------
package ksdq_pkg;

  // storage sizes
  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned ACTIVE_SLOTS = 8;
  localparam int unsigned KEY_BITS     = 16;
  localparam int unsigned TAG_BITS     = 16;

  // counter widths, wide enough to hold the depth itself
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ACNT_W = $clog2(ACTIVE_SLOTS + 1);

  // configuration port sizes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned QLIM_W     = 5;
  localparam int unsigned ALIM_W     = 4;
  localparam logic [QLIM_W-1:0] QLIM_RESET = 5'd16;
  localparam logic [ALIM_W-1:0] ALIM_RESET = 4'd8;

  // field widths of the beats
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned TOTAL_W  = 4;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 48;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUEUE_LIMIT  = 1'd0,
    CFG_ACTIVE_LIMIT = 1'd1
  } cfg_idx_e;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START    = 3'd0,
    KIND_STOP     = 3'd1,
    KIND_SUBMIT   = 3'd2,
    KIND_DISPATCH = 3'd3,
    KIND_RELEASE  = 3'd4
  } kind_e;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK            = 3'd0,
    STAT_QUEUE_FULL    = 3'd1,
    STAT_NOT_ACCEPTING = 3'd2,
    STAT_NONE_ELIGIBLE = 3'd3,
    STAT_DRAINED       = 3'd4,
    STAT_START_REFUSED = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // per-cell update command
  typedef struct packed {
    logic load;   // take the new entry from the top
    logic shift;  // take the entry of the upper neighbour
  } cell_ctl_t;

  typedef logic [ACTIVE_SLOTS-1:0][KEY_BITS-1:0] akey_vec_t;

endpackage

@@ hdl/ksdq_queue_cell.sv @@
// ----------------------------------------------------------------------------
// ksdq_queue_cell
// One queue slot: holds a key and tag, checks its key against the active set
// and extends the oldest-eligible search chain.
// ----------------------------------------------------------------------------
module ksdq_queue_cell
  import ksdq_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic                valid_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic [KEY_BITS-1:0] nbr_key_i,
  input  logic [TAG_BITS-1:0] nbr_tag_i,
  input  akey_vec_t           act_key_i,
  input  logic [ACTIVE_SLOTS-1:0] act_valid_i,
  input  logic                found_i,
  output logic                found_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                blocked;

  // key already being worked on
  always_comb begin
    blocked = 1'b0;
    for (int j = 0; j < ACTIVE_SLOTS; j++) begin
      if (act_valid_i[j] && (act_key_i[j] == key_q)) blocked = 1'b1;
    end
  end

  // search chain: set from the first eligible slot upwards
  assign found_o = found_i | (valid_i & ~blocked);

  // compaction takes the neighbour, a submit loads the tail
  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctl_i.shift) begin
      key_d = nbr_key_i;
      tag_d = nbr_tag_i;
    end else if (ctl_i.load) begin
      key_d = new_key_i;
      tag_d = new_tag_i;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

@@ hdl/ksdq_active_cell.sv @@
// ----------------------------------------------------------------------------
// ksdq_active_cell
// One active-set slot: holds a key in work and extends the release search
// chain.
// ----------------------------------------------------------------------------
module ksdq_active_cell
  import ksdq_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic                valid_i,
  input  logic [KEY_BITS-1:0] rel_key_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [KEY_BITS-1:0] nbr_key_i,
  input  logic                found_i,
  output logic                found_o,
  output logic [KEY_BITS-1:0] key_o
);

  logic [KEY_BITS-1:0] key_q, key_d;

  // release chain: set from the first matching slot upwards
  assign found_o = found_i | (valid_i & (key_q == rel_key_i));

  // release closes the gap, a grant appends
  always_comb begin
    key_d = key_q;
    if (ctl_i.shift) begin
      key_d = nbr_key_i;
    end else if (ctl_i.load) begin
      key_d = new_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

@@ hdl/keyed_serializing_dispatch_queue.sv @@
// ----------------------------------------------------------------------------
// keyed_serializing_dispatch_queue
// Per-key serialised work queue with dispatch, release and run control.
// ----------------------------------------------------------------------------
// Each input beat carries one command (kind on tuser: start, stop, submit,
// dispatch, release; key and tag on tdata) and yields exactly one result beat
// with status, granted tag and key, and the queue and active counts after the
// command. A command is first captured from the beat; then the row of queue
// cells compares its keys against the active set, picks the oldest eligible
// entry along the cell chain and compacts in place. A new beat is accepted
// only once the previous command has executed; a stalled result holds the
// next command back. The queue and active slots come up empty after reset
// with no clearing pass, and the limit registers may only be written while
// no command is in flight.
// ----------------------------------------------------------------------------
module keyed_serializing_dispatch_queue
  import ksdq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // command beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,  // key_id [15:0], work_tag [31:16]
  input  logic [KIND_W-1:0]     s_axis_tuser,  // kind [2:0]
  // result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_DATA_W-1:0]   m_axis_tdata   // status [2:0], granted_tag [18:3],
                                               // granted_key [34:19],
                                               // queue_depth [39:35],
                                               // active_total [43:40], zero above
);

  // control and configuration state
  state_e              st_q, st_d;
  logic [QLIM_W-1:0]   qlim_reg_q;
  logic [ALIM_W-1:0]   alim_reg_q;
  logic [QCNT_W-1:0]   qcnt_q, qcnt_d;
  logic [ACNT_W-1:0]   acnt_q, acnt_d;
  logic                started_q, started_d;
  logic                stopping_q, stopping_d;

  // captured command
  logic [KIND_W-1:0]   kind_q;
  logic [KEY_BITS-1:0] ikey_q;
  logic [TAG_BITS-1:0] itag_q;

  // result register
  logic                ovalid_q;
  logic [STATUS_W-1:0] ostat_q, ostat_d;
  logic [TAG_BITS-1:0] otag_q, otag_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [QCNT_W-1:0]   odepth_q;
  logic [ACNT_W-1:0]   ototal_q;

  logic in_acc, exec;

  // cell rows
  logic [QUEUE_DEPTH-1:0]               q_valid, q_found;
  logic [QUEUE_DEPTH-1:0][KEY_BITS-1:0] q_key;
  logic [QUEUE_DEPTH-1:0][TAG_BITS-1:0] q_tag;
  cell_ctl_t [QUEUE_DEPTH-1:0]          q_ctl;
  logic [ACTIVE_SLOTS-1:0]              a_valid, a_found;
  akey_vec_t                            a_key;
  cell_ctl_t [ACTIVE_SLOTS-1:0]         a_ctl;

  logic [QCNT_W-1:0]   qlim;
  logic [ACNT_W-1:0]   alim;
  logic                submit_ok, dispatch_ok, release_hit;
  logic [KEY_BITS-1:0] g_key;
  logic [TAG_BITS-1:0] g_tag;

  assign s_axis_tready = (st_q == S_IDLE) && (!ovalid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign exec          = (st_q == S_EXEC) && (!ovalid_q || m_axis_tready);

  // limits clamped into the usable range
  always_comb begin
    if (qlim_reg_q == '0) qlim = QCNT_W'(1);
    else if (QCNT_W'(qlim_reg_q) > QCNT_W'(QUEUE_DEPTH)) qlim = QCNT_W'(QUEUE_DEPTH);
    else qlim = QCNT_W'(qlim_reg_q);
    if (alim_reg_q == '0) alim = ACNT_W'(1);
    else if (ACNT_W'(alim_reg_q) > ACNT_W'(ACTIVE_SLOTS)) alim = ACNT_W'(ACTIVE_SLOTS);
    else alim = ACNT_W'(alim_reg_q);
  end

  // occupancy masks
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) q_valid[i] = QCNT_W'(i) < qcnt_q;
    for (int i = 0; i < ACTIVE_SLOTS; i++) a_valid[i] = ACNT_W'(i) < acnt_q;
  end

  // queue cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_qcell
    logic [KEY_BITS-1:0] nbr_key;
    logic [TAG_BITS-1:0] nbr_tag;
    logic                fin;
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign nbr_key = '0;
      assign nbr_tag = '0;
    end else begin : g_mid
      assign nbr_key = q_key[i+1];
      assign nbr_tag = q_tag[i+1];
    end
    if (i == 0) begin : g_first
      assign fin = 1'b0;
    end else begin : g_rest
      assign fin = q_found[i-1];
    end
    assign q_ctl[i].load  = submit_ok && (QCNT_W'(i) == qcnt_q);
    assign q_ctl[i].shift = dispatch_ok && q_found[i];
    ksdq_queue_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (q_ctl[i]),
      .valid_i     (q_valid[i]),
      .new_key_i   (ikey_q),
      .new_tag_i   (itag_q),
      .nbr_key_i   (nbr_key),
      .nbr_tag_i   (nbr_tag),
      .act_key_i   (a_key),
      .act_valid_i (a_valid),
      .found_i     (fin),
      .found_o     (q_found[i]),
      .key_o       (q_key[i]),
      .tag_o       (q_tag[i])
    );
  end

  // active cell row
  for (genvar i = 0; i < ACTIVE_SLOTS; i++) begin : g_acell
    logic [KEY_BITS-1:0] nbr_key;
    logic                fin;
    if (i == ACTIVE_SLOTS - 1) begin : g_top
      assign nbr_key = '0;
    end else begin : g_mid
      assign nbr_key = a_key[i+1];
    end
    if (i == 0) begin : g_first
      assign fin = 1'b0;
    end else begin : g_rest
      assign fin = a_found[i-1];
    end
    assign a_ctl[i].load  = dispatch_ok && (ACNT_W'(i) == acnt_q);
    assign a_ctl[i].shift = release_hit && a_found[i];
    ksdq_active_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (a_ctl[i]),
      .valid_i   (a_valid[i]),
      .rel_key_i (ikey_q),
      .new_key_i (g_key),
      .nbr_key_i (nbr_key),
      .found_i   (fin),
      .found_o   (a_found[i]),
      .key_o     (a_key[i])
    );
  end

  // pick the entry where the search chain first sets
  always_comb begin
    g_key = '0;
    g_tag = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (q_found[i] && ((i == 0) ? 1'b1 : !q_found[(i == 0) ? 0 : i-1])) begin
        g_key = g_key | q_key[i];
        g_tag = g_tag | q_tag[i];
      end
    end
  end

  // command decode and next state
  always_comb begin
    st_d        = st_q;
    qcnt_d      = qcnt_q;
    acnt_d      = acnt_q;
    started_d   = started_q;
    stopping_d  = stopping_q;
    ostat_d     = STAT_OK;
    otag_d      = '0;
    okey_d      = '0;
    submit_ok   = 1'b0;
    dispatch_ok = 1'b0;
    release_hit = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (in_acc) st_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec) begin
          st_d = S_IDLE;
          case (kind_q)
            KIND_START: begin
              if (started_q || stopping_q) ostat_d = STAT_START_REFUSED;
              else started_d = 1'b1;
            end
            KIND_STOP: begin
              stopping_d = 1'b1;
            end
            KIND_SUBMIT: begin
              if (qcnt_q >= qlim) ostat_d = STAT_QUEUE_FULL;
              else if (!started_q || stopping_q) ostat_d = STAT_NOT_ACCEPTING;
              else begin
                submit_ok = 1'b1;
                qcnt_d    = qcnt_q + QCNT_W'(1);
              end
            end
            KIND_DISPATCH: begin
              if (qcnt_q == '0) ostat_d = stopping_q ? STAT_DRAINED : STAT_NONE_ELIGIBLE;
              else if (acnt_q >= alim) ostat_d = STAT_NONE_ELIGIBLE;
              else if (!q_found[QUEUE_DEPTH-1]) ostat_d = STAT_NONE_ELIGIBLE;
              else begin
                dispatch_ok = 1'b1;
                otag_d      = g_tag;
                okey_d      = g_key;
                qcnt_d      = qcnt_q - QCNT_W'(1);
                acnt_d      = acnt_q + ACNT_W'(1);
              end
            end
            KIND_RELEASE: begin
              if (a_found[ACTIVE_SLOTS-1]) begin
                release_hit = 1'b1;
                acnt_d      = acnt_q - ACNT_W'(1);
              end
            end
            default: ostat_d = STAT_NOT_ACCEPTING;
          endcase
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      qcnt_q     <= '0;
      acnt_q     <= '0;
      started_q  <= 1'b0;
      stopping_q <= 1'b0;
      ovalid_q   <= 1'b0;
      qlim_reg_q <= QLIM_RESET;
      alim_reg_q <= ALIM_RESET;
    end else begin
      st_q       <= st_d;
      qcnt_q     <= qcnt_d;
      acnt_q     <= acnt_d;
      started_q  <= started_d;
      stopping_q <= stopping_d;
      if (exec) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUEUE_LIMIT:  qlim_reg_q <= cfg_wdata_i[QLIM_W-1:0];
          CFG_ACTIVE_LIMIT: alim_reg_q <= cfg_wdata_i[ALIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // command capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      ikey_q <= s_axis_tdata[KEY_BITS-1:0];
      itag_q <= s_axis_tdata[KEY_BITS +: TAG_BITS];
    end
    if (exec) begin
      ostat_q  <= ostat_d;
      otag_q   <= otag_d;
      okey_q   <= okey_d;
      odepth_q <= qcnt_d;
      ototal_q <= acnt_d;
    end
  end

  // result beat
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {
    {(M_DATA_W - STATUS_W - TAG_BITS - KEY_BITS - DEPTH_W - TOTAL_W){1'b0}},
    TOTAL_W'(ototal_q), DEPTH_W'(odepth_q), okey_q, otag_q, ostat_q
  };

  // checks
  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_acnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acnt_q <= ACNT_W'(ACTIVE_SLOTS))
    else $error("active count beyond slots");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == S_EXEC))
    else $error("accepted beat not executed");

  a_grant_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dispatch_ok |=> (acnt_q == $past(acnt_q) + ACNT_W'(1)) &&
                    (qcnt_q == $past(qcnt_q) - QCNT_W'(1)))
    else $error("grant did not move an entry");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(st_q == S_EXEC))
    else $error("result without execution");

endmodule
